### hw/rtl/url_host_port_path_parser_unit_assert.svh
// Assertion macros for the URL host/port/path parser.
// Used by the top level; no other dependencies.
`ifndef URL_HOST_PORT_PATH_PARSER_UNIT_ASSERT_SVH
`define URL_HOST_PORT_PATH_PARSER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define UHPP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);
`define UHPP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define UHPP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define UHPP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

### hw/rtl/uhpp_pkg.sv
// Shared types and constants of the URL host/port/path parser.
// No dependencies.
package uhpp_pkg;

	localparam int MAX_URL_LEN_DEF  = 127;
	localparam int MAX_HOST_LEN_DEF = 63;

	localparam int          ADDR_W           = 3;
	localparam logic [15:0] DEFAULT_PORT_RST = 16'd80;
	localparam logic        REG_DEFAULT_PORT = 1'b0;

	localparam logic [1:0] REG_HOST  = 2'd0;
	localparam logic [1:0] REG_COLON = 2'd1;
	localparam logic [1:0] REG_PORT  = 2'd2;
	localparam logic [1:0] REG_PATH  = 2'd3;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [9:0] OCTET_MAX  = 10'd255;
	localparam logic [1:0] GROUP_FULL = 2'd3;
	localparam logic [1:0] OCTET_LAST = 2'd3;

	typedef struct packed {
		logic [7:0] url_char;
		logic       is_last;
	} char_word_t;

	typedef struct packed {
		logic [7:0]  char_out;
		logic [1:0]  region;
		logic        done_res;
		logic        host_ipv4;
		logic [31:0] ip_address;
		logic [15:0] port;
		logic        path_is_default;
		logic        too_long;
	} res_word_t;

endpackage

### hw/rtl/uhpp_cfg_regs.sv
// APB-style configuration register: default port.
// Depends on uhpp_pkg.
module uhpp_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [uhpp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [15:0]                 default_port
);
	import uhpp_pkg::*;

	logic [15:0] default_port_q;
	logic        sel_port;

	assign sel_port = (paddr[ADDR_W-1] == REG_DEFAULT_PORT);
	assign pready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_port_q <= DEFAULT_PORT_RST;
		end else if (psel && penable && pwrite && pready && sel_port) begin
			default_port_q <= pwdata[15:0];
		end
	end

	assign prdata       = sel_port ? {16'd0, default_port_q} : 32'd0;
	assign default_port = default_port_q;

endmodule

### hw/rtl/uhpp_parse_core.sv
// Running parse state and single-pass next-state/result logic.
// Depends on uhpp_pkg.
module uhpp_parse_core #(
	parameter int MAX_URL_LEN  = uhpp_pkg::MAX_URL_LEN_DEF,
	parameter int MAX_HOST_LEN = uhpp_pkg::MAX_HOST_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  uhpp_pkg::char_word_t word,
	input  logic [15:0]          default_port,
	output uhpp_pkg::res_word_t  res
);
	import uhpp_pkg::*;

	localparam int ULW = $clog2(MAX_URL_LEN + 1);
	localparam int HLW = $clog2(MAX_HOST_LEN + 1);

	logic [1:0]     region_q, region_n;
	logic [1:0]     octet_q, octet_n;
	logic [1:0]     grp_dig_q, grp_dig_n;
	logic [9:0]     grp_val_q, grp_val_n;
	logic [31:0]    ip_q, ip_n;
	logic           ip_ok_q, ip_ok_n;
	logic [15:0]    port_q, port_n;
	logic           port_stop_q, port_stop_n;
	logic           colon_q, colon_n;
	logic [ULW-1:0] url_len_q, url_len_n;
	logic [HLW-1:0] host_len_q, host_len_n;
	logic           ovf_q, ovf_n;

	logic [7:0] c;
	logic [3:0] dig;
	logic       is_digit;
	logic       grp_ok;
	logic       is_ip;
	logic [1:0] reg_tag;

	assign c        = word.url_char;
	assign dig      = 4'(c - CH_ZERO);
	assign is_digit = c inside {[CH_ZERO:CH_NINE]};
	assign grp_ok   = (grp_dig_q != 2'd0) && (grp_val_q <= OCTET_MAX);

	always_comb begin
		region_n    = region_q;
		octet_n     = octet_q;
		grp_dig_n   = grp_dig_q;
		grp_val_n   = grp_val_q;
		ip_n        = ip_q;
		ip_ok_n     = ip_ok_q;
		port_n      = port_q;
		port_stop_n = port_stop_q;
		colon_n     = colon_q;
		url_len_n   = url_len_q;
		host_len_n  = host_len_q;
		ovf_n       = ovf_q;

		if (url_len_q >= ULW'(MAX_URL_LEN)) begin
			ovf_n = 1'b1;
		end else begin
			url_len_n = url_len_q + 1'b1;
		end

		if (region_q == REG_PATH || c == CH_SLASH) begin
			reg_tag  = REG_PATH;
			region_n = REG_PATH;
		end else if (region_q == REG_HOST && c == CH_COLON) begin
			reg_tag  = REG_COLON;
			region_n = REG_PORT;
			colon_n  = 1'b1;
		end else if (region_q == REG_HOST) begin
			reg_tag = REG_HOST;
			if (host_len_q >= HLW'(MAX_HOST_LEN)) begin
				ovf_n = 1'b1;
			end else begin
				host_len_n = host_len_q + 1'b1;
			end
			if (ip_ok_q) begin
				if (c == CH_DOT) begin
					if (grp_ok && octet_q != OCTET_LAST) begin
						ip_n      = {ip_q[23:0], grp_val_q[7:0]};
						octet_n   = octet_q + 1'b1;
						grp_dig_n = 2'd0;
						grp_val_n = 10'd0;
					end else begin
						ip_ok_n = 1'b0;
					end
				end else if (is_digit) begin
					if (grp_dig_q == GROUP_FULL) begin
						ip_ok_n = 1'b0;
					end else begin
						grp_dig_n = grp_dig_q + 1'b1;
						grp_val_n = (grp_val_q << 3) + (grp_val_q << 1) + 10'(dig);
					end
				end else begin
					ip_ok_n = 1'b0;
				end
			end
		end else begin
			reg_tag = REG_PORT;
			if (!port_stop_q) begin
				if (is_digit) begin
					port_n = (port_q << 3) + (port_q << 1) + 16'(dig);
				end else begin
					port_stop_n = 1'b1;
				end
			end
		end
	end

	assign is_ip = ip_ok_n && (octet_n == OCTET_LAST) && (grp_dig_n != 2'd0)
		&& (grp_val_n <= OCTET_MAX);

	always_comb begin
		res                 = '0;
		res.char_out        = c;
		res.region          = reg_tag;
		res.done_res        = word.is_last;
		if (word.is_last) begin
			res.host_ipv4       = is_ip;
			res.ip_address      = is_ip ? {ip_n[23:0], grp_val_n[7:0]} : 32'd0;
			res.port            = colon_n ? port_n : default_port;
			res.path_is_default = (region_n != REG_PATH);
			res.too_long        = ovf_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q    <= REG_HOST;
			octet_q     <= '0;
			grp_dig_q   <= '0;
			grp_val_q   <= '0;
			ip_q        <= '0;
			ip_ok_q     <= 1'b1;
			port_q      <= '0;
			port_stop_q <= 1'b0;
			colon_q     <= 1'b0;
			url_len_q   <= '0;
			host_len_q  <= '0;
			ovf_q       <= 1'b0;
		end else if (adv && word.is_last) begin
			region_q    <= REG_HOST;
			octet_q     <= '0;
			grp_dig_q   <= '0;
			grp_val_q   <= '0;
			ip_q        <= '0;
			ip_ok_q     <= 1'b1;
			port_q      <= '0;
			port_stop_q <= 1'b0;
			colon_q     <= 1'b0;
			url_len_q   <= '0;
			host_len_q  <= '0;
			ovf_q       <= 1'b0;
		end else if (adv) begin
			region_q    <= region_n;
			octet_q     <= octet_n;
			grp_dig_q   <= grp_dig_n;
			grp_val_q   <= grp_val_n;
			ip_q        <= ip_n;
			ip_ok_q     <= ip_ok_n;
			port_q      <= port_n;
			port_stop_q <= port_stop_n;
			colon_q     <= colon_n;
			url_len_q   <= url_len_n;
			host_len_q  <= host_len_n;
			ovf_q       <= ovf_n;
		end
	end

endmodule

### hw/rtl/url_host_port_path_parser_unit.sv
// Top level of the URL host/port/path parser: input and result registers, handshake.
// Depends on uhpp_pkg, uhpp_cfg_regs, uhpp_parse_core and the assertion header.
//
//   channel  dir  handshake               payload
//   char     in   char_valid/char_stall   char_word (url_char, is_last)
//   res      out  res_valid/res_stall     res_word (one result per character)
//   cfg      in   APB psel/penable/...    default_port at byte address 0
//
// One character per cycle sustained while res_stall is low; res_valid rises when
// the word goes from input to result register; the parse core sets the rate.
// Reset returns the parse state to the host region and default_port to 80.
// A stalled result holds; the input register still takes one more word behind it.
`include "url_host_port_path_parser_unit_assert.svh"
module url_host_port_path_parser_unit #(
	parameter int MAX_URL_LEN  = uhpp_pkg::MAX_URL_LEN_DEF,
	parameter int MAX_HOST_LEN = uhpp_pkg::MAX_HOST_LEN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        char_valid,
	output logic                        char_stall,
	input  uhpp_pkg::char_word_t        char_word,
	output logic                        res_valid,
	input  logic                        res_stall,
	output uhpp_pkg::res_word_t         res_word,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [uhpp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import uhpp_pkg::*;

	char_word_t  word_s1;
	logic        valid_s1;
	res_word_t   res_word_q;
	logic        res_valid_q;
	res_word_t   res_comb;
	logic [15:0] default_port;
	logic        out_free;
	logic        adv;
	logic        accept;

	assign out_free   = !res_valid_q || !res_stall;
	assign adv        = valid_s1 && out_free;
	assign char_stall = valid_s1 && !out_free;
	assign accept     = char_valid && !char_stall;

	uhpp_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.default_port (default_port)
	);

	uhpp_parse_core #(
		.MAX_URL_LEN  (MAX_URL_LEN),
		.MAX_HOST_LEN (MAX_HOST_LEN)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.word         (word_s1),
		.default_port (default_port),
		.res          (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				res_valid_q <= adv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= char_word;
		end
		if (adv) begin
			res_word_q <= res_comb;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

	`UHPP_ASSERT_NXT(a_accept_lands, clk, arst_n, accept, valid_s1, "accepted word lost")
	`UHPP_ASSERT_IMP(a_stall_cause, clk, arst_n, char_stall,
		valid_s1 && res_valid_q && res_stall, "input stalled without a full pipeline")
	`UHPP_ASSERT_IMP(a_summary_zero, clk, arst_n, res_valid_q && !res_word_q.done_res,
		!res_word_q.host_ipv4 && res_word_q.port == 16'd0 && !res_word_q.too_long
		&& !res_word_q.path_is_default, "summary fields set before last word")
	`UHPP_ASSERT_IMP(a_ip_zero, clk, arst_n, res_valid_q && !res_word_q.host_ipv4,
		res_word_q.ip_address == 32'd0, "address reported for non-IP host")

endmodule

### verif/url_host_port_path_parser_unit_checker.sv
`timescale 1ns / 100ps
// Checker for the URL host/port/path parser: watches the character, result and APB channels,
// predicts every result word from its own parse state and compares it field by field.
// Depends on uhpp_pkg.
module url_host_port_path_parser_unit_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        char_valid,
	input  logic                        char_stall,
	input  uhpp_pkg::char_word_t        char_word,
	input  logic                        res_valid,
	input  logic                        res_stall,
	input  uhpp_pkg::res_word_t         res_word,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [uhpp_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	input  logic [31:0]                 prdata,
	input  logic                        pready,
	output int                          errors,
	output int                          pending
);
	import uhpp_pkg::*;

	localparam logic [ADDR_W-1:0] DPORT_ADDR = ADDR_W'(4 * int'(REG_DEFAULT_PORT));

	res_word_t   parsed_q[$];
	res_word_t   want_w;
	logic [15:0] dflt_port;

	logic [1:0]  cur_region;
	logic [2:0]  octet_idx;
	logic [2:0]  grp_digits;
	logic [9:0]  grp_value;
	logic [31:0] ip_acc;
	logic        ip_ok;
	logic [15:0] port_acc;
	logic        port_done;
	logic        colon_seen;
	logic [7:0]  url_len;
	logic [6:0]  host_len;
	logic        overlong;

	function automatic void clear_parse();
		cur_region = REG_HOST;
		octet_idx  = '0;
		grp_digits = '0;
		grp_value  = '0;
		ip_acc     = '0;
		ip_ok      = 1'b1;
		port_acc   = '0;
		port_done  = 1'b0;
		colon_seen = 1'b0;
		url_len    = '0;
		host_len   = '0;
		overlong   = 1'b0;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic group_fits();
		return grp_digits >= 1 && grp_digits <= GROUP_FULL && grp_value <= OCTET_MAX;
	endfunction

	function automatic void host_step(logic [7:0] c);
		if (host_len >= MAX_HOST_LEN_DEF) overlong = 1'b1;
		if (host_len != 7'h7F) host_len++;
		if (!ip_ok) return;
		if (c == CH_DOT) begin
			if (group_fits() && octet_idx < OCTET_LAST) begin
				ip_acc     = {ip_acc[23:0], grp_value[7:0]};
				octet_idx  = octet_idx + 1'b1;
				grp_digits = '0;
				grp_value  = '0;
			end else begin
				ip_ok = 1'b0;
			end
		end else if (is_digit(c)) begin
			if (grp_digits >= GROUP_FULL) begin
				ip_ok = 1'b0;
			end else begin
				grp_digits = grp_digits + 1'b1;
				grp_value  = 10'(grp_value * 10 + (c - CH_ZERO));
			end
		end else begin
			ip_ok = 1'b0;
		end
	endfunction

	function automatic res_word_t parse_char(char_word_t w);
		res_word_t  r;
		logic [1:0] tag;
		logic [7:0] c;
		c = w.url_char;
		if (url_len >= MAX_URL_LEN_DEF) overlong = 1'b1;
		if (url_len != 8'hFF) url_len++;
		if (cur_region == REG_PATH || c == CH_SLASH) begin
			tag        = REG_PATH;
			cur_region = REG_PATH;
		end else if (cur_region == REG_HOST && c == CH_COLON) begin
			tag        = REG_COLON;
			cur_region = REG_PORT;
			colon_seen = 1'b1;
		end else if (cur_region == REG_HOST) begin
			tag = REG_HOST;
			host_step(c);
		end else begin
			tag = REG_PORT;
			if (!port_done) begin
				if (is_digit(c)) port_acc = 16'(port_acc * 10 + (c - CH_ZERO));
				else port_done = 1'b1;
			end
		end
		r          = '0;
		r.char_out = c;
		r.region   = tag;
		r.done_res = w.is_last;
		if (w.is_last) begin
			if (ip_ok && octet_idx == OCTET_LAST && group_fits()) begin
				r.host_ipv4  = 1'b1;
				r.ip_address = {ip_acc[23:0], grp_value[7:0]};
			end
			r.port            = colon_seen ? port_acc : dflt_port;
			r.path_is_default = (cur_region != REG_PATH);
			r.too_long        = overlong;
			clear_parse();
		end
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %h got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_port = DEFAULT_PORT_RST;
			clear_parse();
			parsed_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (parsed_q.size() == 0) begin
					errors++;
					$display("%0t: result word expected none got %h", $time, res_word);
				end else begin
					want_w = parsed_q.pop_front();
					check_field("char_out", want_w.char_out, res_word.char_out);
					check_field("region", want_w.region, res_word.region);
					check_field("done_res", want_w.done_res, res_word.done_res);
					check_field("host_ipv4", want_w.host_ipv4, res_word.host_ipv4);
					check_field("ip_address", want_w.ip_address, res_word.ip_address);
					check_field("port", want_w.port, res_word.port);
					check_field("path_is_default", want_w.path_is_default,
						res_word.path_is_default);
					check_field("too_long", want_w.too_long, res_word.too_long);
				end
			end
			if (char_valid && !char_stall) parsed_q.push_back(parse_char(char_word));
			if (psel && penable && pready && paddr == DPORT_ADDR) begin
				if (pwrite) dflt_port = pwdata[15:0];
				else check_field("default_port", dflt_port, prdata[15:0]);
			end
			pending = parsed_q.size();
		end
	end

endmodule

### verif/tb_url_host_port_path_parser_unit.sv
`timescale 1ns / 100ps
// Testbench top of the URL host/port/path parser: clock, reset, APB setup, URL stimulus and
// stall patterns; the checker module beside the block predicts and compares.
// Depends on uhpp_pkg, url_host_port_path_parser_unit and url_host_port_path_parser_unit_checker.
module tb_url_host_port_path_parser_unit;
	import uhpp_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 120;
	localparam int PHASE_CHARS    = 610;
	localparam logic [ADDR_W-1:0] DPORT_ADDR = ADDR_W'(4 * int'(REG_DEFAULT_PORT));
	localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4 * (int'(REG_DEFAULT_PORT) + 1));

	logic              clk;
	logic              arst_n;
	logic              char_valid;
	logic              char_stall;
	char_word_t        char_word;
	logic              res_valid;
	logic              res_stall;
	res_word_t         res_word;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	int                errors;
	int                pending;

	logic [7:0] url_buf[$];
	int         tx_idle_pct;
	int         rx_idle_pct;
	int         hold_req = 0;
	int         hold_left = 0;
	int         sent_chars = 0;
	int         quiet_cycles = 0;

	url_host_port_path_parser_unit uut (.*);

	url_host_port_path_parser_unit_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (char_valid && !char_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_url_host_port_path_parser_unit failed");
			$finish;
		end
	end

	task automatic send_char(input logic [7:0] c, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_word  <= '{url_char: c, is_last: last};
		@(posedge clk);
		while (char_stall) @(posedge clk);
		sent_chars++;
	endtask

	task automatic send_url();
		for (int i = 0; i < url_buf.size(); i++)
			send_char(url_buf[i], i == url_buf.size() - 1);
		url_buf.delete();
	endtask

	task automatic push_str(string s);
		for (int i = 0; i < s.len(); i++)
			url_buf.push_back(s[i]);
	endtask

	task automatic directed_url(string s);
		push_str(s);
		send_url();
	endtask

	task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
			input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		char_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] name_char();
		int k;
		k = $urandom_range(39);
		if (k < 26) return 8'h61 + 8'(k);
		if (k < 36) return CH_ZERO + 8'(k - 26);
		if (k < 38) return CH_DOT;
		return 8'h2D;
	endfunction

	function automatic logic [7:0] path_char();
		int k;
		k = $urandom_range(19);
		if (k == 0) return CH_COLON;
		if (k == 1) return CH_SLASH;
		if (k == 2) return 8'($urandom_range(255));
		return name_char();
	endfunction

	task automatic push_ip_host();
		int groups;
		int v;
		groups = ($urandom_range(9) == 0) ? $urandom_range(3, 5) : 4;
		for (int g = 0; g < groups; g++) begin
			if (g != 0) url_buf.push_back(CH_DOT);
			if ($urandom_range(24) == 0) continue;
			case ($urandom_range(9))
				0: v = 0;
				1: v = 255;
				2: v = $urandom_range(256, 999);
				default: v = $urandom_range(255);
			endcase
			if ($urandom_range(6) == 0) url_buf.push_back(CH_ZERO);
			push_str($sformatf("%0d", v));
		end
	endtask

	task automatic build_url(input bit force_long);
		int  kind;
		int  n;
		bit  long_url;
		kind     = $urandom_range(99);
		long_url = force_long || kind >= 96;
		if (long_url) begin
			n = $urandom_range(56, 140);
			repeat (n) url_buf.push_back(name_char());
		end else if (kind < 55) begin
			push_ip_host();
		end else if (kind < 78) begin
			n = $urandom_range(1, 12);
			repeat (n) url_buf.push_back(name_char());
		end else if (kind < 86) begin
			n = $urandom_range(1, 8);
			repeat (n) url_buf.push_back(8'($urandom_range(255)));
		end
		if ($urandom_range(1) == 1) begin
			url_buf.push_back(CH_COLON);
			n = $urandom_range(6);
			repeat (n) url_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
			if ($urandom_range(5) == 0) url_buf.push_back(8'($urandom_range(255)));
		end
		if (long_url || $urandom_range(1) == 1) begin
			url_buf.push_back(CH_SLASH);
			n = long_url ? $urandom_range(100, 200) : $urandom_range(10);
			repeat (n) url_buf.push_back(path_char());
		end
		if (url_buf.size() == 0 || $urandom_range(19) == 0)
			url_buf.push_back(8'($urandom_range(255)));
		if ($urandom_range(19) == 0)
			url_buf[$urandom_range(url_buf.size() - 1)] = 8'($urandom_range(255));
	endtask

	task automatic random_phase();
		int start;
		start = sent_chars;
		build_url(1'b1);
		send_url();
		while (sent_chars - start < PHASE_CHARS) begin
			build_url(1'b0);
			send_url();
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		char_valid  <= 1'b0;
		char_word   <= '0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		tx_idle_pct = 37;
		rx_idle_pct = 68;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_access(1'b0, DPORT_ADDR, '0);
		directed_url("1.2.3.4:80/a");
		directed_url("255.255.255.255");
		directed_url("0.0.0.0:65535/");
		directed_url("256.1.1.1");
		directed_url("1.2.3");
		directed_url("1.2.3.4.5");
		directed_url("0001.2.3.4");
		directed_url("01.2..4:");
		directed_url("h:12a3/x:y");
		directed_url("a:99999");
		directed_url("/");
		directed_url(":");
		url_buf = '{8'hFF, 8'h00, CH_COLON, 8'h37, 8'h00, 8'h39};
		send_url();
		drain();

		apb_access(1'b1, DPORT_ADDR, 32'h0);
		apb_access(1'b1, SPARE_ADDR, $urandom());
		apb_access(1'b0, DPORT_ADDR, '0);
		random_phase();
		drain();

		tx_idle_pct = 68;
		rx_idle_pct = 37;
		apb_access(1'b1, DPORT_ADDR, 32'hFFFF_FFFF);
		apb_access(1'b0, DPORT_ADDR, '0);
		random_phase();
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		apb_access(1'b1, DPORT_ADDR, $urandom());
		apb_access(1'b0, DPORT_ADDR, '0);
		hold_req = 1;
		random_phase();
		drain();

		if (errors == 0 && pending == 0)
			$display("tb_url_host_port_path_parser_unit passed");
		else
			$display("tb_url_host_port_path_parser_unit failed");
		$finish;
	end

endmodule
